[src/ips_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types, register codes and the limit clamp of the integer PID step.
// ----------------------------------------------------------------------------
package ips_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int GAIN_W      = 16;
  localparam int SAMPLE_W    = 16;
  localparam int DRIVE_W     = 32;
  localparam int ERR_W       = SAMPLE_W + 1;
  localparam int PROD_W      = GAIN_W + ERR_W;
  localparam int SUM_W       = PROD_W + 2;

  localparam logic signed [DRIVE_W-1:0] LIMIT_HIGH_RESET = 32'sd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_HIGH = 3'd5,
    REG_AUTO_CFG   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [DRIVE_W-1:0]  limit_low;
    logic signed [DRIVE_W-1:0]  limit_high;
    logic                       auto_en;
    logic                       clamp_int;
  } cfg_t;

  function automatic logic signed [DRIVE_W-1:0] lim_clamp(
    input logic signed [SUM_W-1:0]   x,
    input logic signed [DRIVE_W-1:0] lo,
    input logic signed [DRIVE_W-1:0] hi
  );
    logic signed [DRIVE_W-1:0] res;
    if (x > SUM_W'(hi)) begin
      res = hi;
    end else if (x < SUM_W'(lo)) begin
      res = lo;
    end else begin
      res = DRIVE_W'(x);
    end
    return res;
  endfunction

endpackage

[src/integer_pid_step_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_pid_step_unit
// Integer PID step with derivative on measurement, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one measured sample per transfer; out_valid/
//   out_ready carry one result (drive, computed) per sample, in order.
//   cfg_wr_en/cfg_index/cfg_wr_data write one register per cycle, no wait.
// Order: a sample is held in the sample register, then its result in the
//   result register.
// Throughput: one sample per cycle unless stalled; the integral and previous
//   sample are updated in the same cycle the result is formed, so the integral
//   multiply, add and clamp feeding the output sum set the clock period.
// Stall: while out_ready is low the result register holds; one more
//   sample is still taken into the sample register, then in_ready drops.
// Reset: both channels empty, integral and previous sample cleared,
//   limits 0..255, gains and setpoint 0, automatic mode on.
// A limit write in automatic mode registers a flag that clamps the integral.
// In manual mode drive is 0 with computed low and the state is kept.
// ----------------------------------------------------------------------------
module integer_pid_step_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ips_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ips_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ips_pkg::DRIVE_W-1:0]   out_drive,
  output logic                                 out_computed
);
  import ips_pkg::*;

  cfg_t cfg;

  ips_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg_o       (cfg)
  );

  ips_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive    (out_drive),
    .out_computed (out_computed)
  );

endmodule

[src/ips_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_cfg
// Configuration registers; flags an integral clamp after a limit write.
// ----------------------------------------------------------------------------
module ips_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ips_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ips_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  output ips_pkg::cfg_t                     cfg_o
);
  import ips_pkg::*;

  logic signed [SAMPLE_W-1:0] setpoint_r,   setpoint_nxt;
  logic signed [GAIN_W-1:0]   gain_p_r,     gain_p_nxt;
  logic signed [GAIN_W-1:0]   gain_i_r,     gain_i_nxt;
  logic signed [GAIN_W-1:0]   gain_d_r,     gain_d_nxt;
  logic signed [DRIVE_W-1:0]  limit_low_r,  limit_low_nxt;
  logic signed [DRIVE_W-1:0]  limit_high_r, limit_high_nxt;
  logic                       auto_en_r,    auto_en_nxt;
  logic                       clamp_int_r,  clamp_int_nxt;
  logic signed [DRIVE_W-1:0]  wr_lim;

  assign wr_lim = cfg_wr_data[DRIVE_W-1:0];

  always_comb begin
    setpoint_nxt   = setpoint_r;
    gain_p_nxt     = gain_p_r;
    gain_i_nxt     = gain_i_r;
    gain_d_nxt     = gain_d_r;
    limit_low_nxt  = limit_low_r;
    limit_high_nxt = limit_high_r;
    auto_en_nxt    = auto_en_r;
    clamp_int_nxt  = 1'b0;
    if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_SETPOINT: setpoint_nxt = cfg_wr_data[SAMPLE_W-1:0];
        REG_GAIN_P:   gain_p_nxt   = cfg_wr_data[GAIN_W-1:0];
        REG_GAIN_I:   gain_i_nxt   = cfg_wr_data[GAIN_W-1:0];
        REG_GAIN_D:   gain_d_nxt   = cfg_wr_data[GAIN_W-1:0];
        REG_LIMIT_LOW: begin
          // limits must stay strictly ordered, otherwise the write is dropped
          if (wr_lim < limit_high_r) begin
            limit_low_nxt = wr_lim;
            clamp_int_nxt = auto_en_r;
          end
        end
        REG_LIMIT_HIGH: begin
          if (wr_lim > limit_low_r) begin
            limit_high_nxt = wr_lim;
            clamp_int_nxt  = auto_en_r;
          end
        end
        REG_AUTO_CFG: auto_en_nxt = cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= '0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      limit_low_r  <= '0;
      limit_high_r <= LIMIT_HIGH_RESET;
      auto_en_r    <= 1'b1;
      clamp_int_r  <= 1'b0;
    end else begin
      setpoint_r   <= setpoint_nxt;
      gain_p_r     <= gain_p_nxt;
      gain_i_r     <= gain_i_nxt;
      gain_d_r     <= gain_d_nxt;
      limit_low_r  <= limit_low_nxt;
      limit_high_r <= limit_high_nxt;
      auto_en_r    <= auto_en_nxt;
      clamp_int_r  <= clamp_int_nxt;
    end
  end

  always_comb begin
    cfg_o.setpoint   = setpoint_r;
    cfg_o.gain_p     = gain_p_r;
    cfg_o.gain_i     = gain_i_r;
    cfg_o.gain_d     = gain_d_r;
    cfg_o.limit_low  = limit_low_r;
    cfg_o.limit_high = limit_high_r;
    cfg_o.auto_en    = auto_en_r;
    cfg_o.clamp_int  = clamp_int_r;
  end

endmodule

[src/ips_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_core
// Sample register, combinational PID step with state, and result register.
// ----------------------------------------------------------------------------
module ips_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ips_pkg::cfg_t                       cfg_i,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ips_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ips_pkg::DRIVE_W-1:0]  out_drive,
  output logic                                out_computed
);
  import ips_pkg::*;

  logic                       smp_valid_r, smp_valid_nxt;
  logic signed [SAMPLE_W-1:0] smp_r;
  logic signed [DRIVE_W-1:0]  integral_r, integral_nxt;
  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [DRIVE_W-1:0]  drive_r;
  logic                       computed_r;

  logic                       res_load;
  logic                       advance;
  logic signed [ERR_W-1:0]    err_raw;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    diff;
  logic signed [PROD_W-1:0]   prod_i;
  logic signed [PROD_W-1:0]   prod_p;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [SUM_W-1:0]    isum;
  logic signed [DRIVE_W-1:0]  int_new;
  logic signed [SUM_W-1:0]    osum;
  logic signed [DRIVE_W-1:0]  drive_new;

  assign res_load = !out_valid_r || out_ready;
  assign advance  = smp_valid_r && res_load;
  assign in_ready = !smp_valid_r || res_load;

  always_comb begin
    err_raw = ERR_W'(cfg_i.setpoint) - ERR_W'(smp_r);
    // a zero error still nudges the integral
    err     = (err_raw == '0) ? ERR_W'(1) : err_raw;
    diff    = ERR_W'(smp_r) - ERR_W'(prev_r);
    prod_i  = PROD_W'(cfg_i.gain_i) * PROD_W'(err);
    prod_p  = PROD_W'(cfg_i.gain_p) * PROD_W'(err);
    prod_d  = PROD_W'(cfg_i.gain_d) * PROD_W'(diff);
    isum    = SUM_W'(integral_r) + SUM_W'(prod_i);
    int_new = lim_clamp(isum, cfg_i.limit_low, cfg_i.limit_high);
    osum    = SUM_W'(prod_p) + SUM_W'(int_new) - SUM_W'(prod_d);
    drive_new = lim_clamp(osum, cfg_i.limit_low, cfg_i.limit_high);
  end

  always_comb begin
    smp_valid_nxt = smp_valid_r;
    if (in_valid && in_ready) begin
      smp_valid_nxt = 1'b1;
    end else if (advance) begin
      smp_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    integral_nxt = integral_r;
    prev_nxt     = prev_r;
    if (advance && cfg_i.auto_en) begin
      integral_nxt = int_new;
      prev_nxt     = smp_r;
    end else if (cfg_i.clamp_int) begin
      integral_nxt = lim_clamp(SUM_W'(integral_r), cfg_i.limit_low, cfg_i.limit_high);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      integral_r  <= '0;
      prev_r      <= '0;
    end else begin
      smp_valid_r <= smp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      integral_r  <= integral_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp_r <= in_sample;
    end
    if (advance) begin
      drive_r    <= cfg_i.auto_en ? drive_new : '0;
      computed_r <= cfg_i.auto_en;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_drive    = drive_r;
  assign out_computed = computed_r;

endmodule

[src/ips_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ips_checker
// Port-level checks on the integer PID step, bound to the top level.
// ----------------------------------------------------------------------------
module ips_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ips_pkg::DRIVE_W-1:0]   out_drive,
  input logic                                 out_computed
);
  import ips_pkg::*;

  // reset empties the result channel
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // manual results always carry a zero drive
  a_manual_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_computed |-> out_drive == '0)
    else $error("non-zero drive without computation");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_computed))
    else $error("stalled result changed");

  // out_valid follows each sample transfer through the sample register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready ##1 rst_n |=> out_valid)
    else $error("no result two cycles after sample transfer");

endmodule

bind integer_pid_step_unit ips_checker u_ips_checker (.*);

[test/integer_pid_step_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_pid_step_unit_tb
// Self-checking bench for the integer PID step with derivative on measurement.
// Samples go in over a valid/ready channel with random gaps, and results come
// back under random output stalls. A local copy of the controller state and
// registers predicts drive and computed for every sample. Covered: directed
// extremes, limit writes that clamp or are rejected, manual mode, a long
// output stall, and randomised register phases.
// ----------------------------------------------------------------------------
module integer_pid_step_unit_tb;
  import ips_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int HOLD_CYCLES    = 40;
  localparam int PHASES         = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS    = 20;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      computed;
  } pid_result_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wr_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [DRIVE_W-1:0]  out_drive;
  logic                       out_computed;

  // local copy of the registers and controller state
  logic signed [SAMPLE_W-1:0] m_setpoint;
  logic signed [GAIN_W-1:0]   m_gain_p;
  logic signed [GAIN_W-1:0]   m_gain_i;
  logic signed [GAIN_W-1:0]   m_gain_d;
  logic signed [DRIVE_W-1:0]  m_lim_lo;
  logic signed [DRIVE_W-1:0]  m_lim_hi;
  logic                       m_auto;
  longint                     m_integral;
  longint                     m_prev_sample;

  pid_result_t pending_drives[$];

  int  n_sent;
  int  n_checked;
  int  n_errors;
  int  n_computed;
  int  n_manual;
  int  n_settings;
  bit  full_rate;
  bit  hold_request;

  integer_pid_step_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_drive    (out_drive),
    .out_computed (out_computed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint clamp_to_limits(input longint x);
    if (x > longint'(m_lim_hi)) begin
      return longint'(m_lim_hi);
    end
    if (x < longint'(m_lim_lo)) begin
      return longint'(m_lim_lo);
    end
    return x;
  endfunction

  function automatic void reset_pid_state();
    m_setpoint    = '0;
    m_gain_p      = '0;
    m_gain_i      = '0;
    m_gain_d      = '0;
    m_lim_lo      = '0;
    m_lim_hi      = LIMIT_HIGH_RESET;
    m_auto        = 1'b1;
    m_integral    = 0;
    m_prev_sample = 0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    logic signed [DRIVE_W-1:0] v;
    v = signed'(data);
    case (idx)
      REG_SETPOINT: m_setpoint = signed'(data[SAMPLE_W-1:0]);
      REG_GAIN_P:   m_gain_p = signed'(data[GAIN_W-1:0]);
      REG_GAIN_I:   m_gain_i = signed'(data[GAIN_W-1:0]);
      REG_GAIN_D:   m_gain_d = signed'(data[GAIN_W-1:0]);
      REG_LIMIT_LOW: begin
        // a low limit at or above the high limit is dropped
        if (v < m_lim_hi) begin
          m_lim_lo = v;
          if (m_auto) m_integral = clamp_to_limits(m_integral);
        end
      end
      REG_LIMIT_HIGH: begin
        if (v > m_lim_lo) begin
          m_lim_hi = v;
          if (m_auto) m_integral = clamp_to_limits(m_integral);
        end
      end
      REG_AUTO_CFG: m_auto = data[0];
      default: ;
    endcase
  endfunction

  function automatic pid_result_t pid_step(input logic signed [SAMPLE_W-1:0] s);
    pid_result_t r;
    longint err;
    longint outv;
    if (!m_auto) begin
      r.drive    = '0;
      r.computed = 1'b0;
      return r;
    end
    err = longint'(m_setpoint) - longint'(s);
    if (err == 0) err = 1;
    m_integral = clamp_to_limits(m_integral + longint'(m_gain_i) * err);
    outv = longint'(m_gain_p) * err + m_integral
         - longint'(m_gain_d) * (longint'(s) - m_prev_sample);
    r.drive       = DRIVE_W'(clamp_to_limits(outv));
    r.computed    = 1'b1;
    m_prev_sample = longint'(s);
    return r;
  endfunction

  // one register write, then a wait that leaves room for the integral clamp
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = full_rate ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    pending_drives.push_back(pid_step(s));
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return m_setpoint;
      1:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      2, 3:    return m_setpoint + SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [GAIN_W-1:0] pick_gain(input int ph);
    if (ph == 0) return 16'sh7fff;
    if (ph == 1) return 16'sh8000;
    case ($urandom_range(0, 6))
      0:       return 16'sd0;
      1:       return 16'sd1;
      2:       return -16'sd1;
      3:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      4, 5:    return GAIN_W'($urandom_range(0, 64)) - 16'sd32;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic set_random_config(input int ph);
    logic signed [DRIVE_W-1:0] lo;
    logic signed [DRIVE_W-1:0] hi;
    logic signed [DRIVE_W-1:0] t;
    write_reg(REG_AUTO_CFG, (ph == 6) ? 32'd0 : 32'd1);
    write_reg(REG_SETPOINT, 32'(pick_gain(ph)));
    write_reg(REG_GAIN_P, 32'(pick_gain(ph)));
    write_reg(REG_GAIN_I, 32'(pick_gain(ph)));
    write_reg(REG_GAIN_D, 32'(pick_gain(ph)));
    if (ph == 0) begin
      lo = 32'sh8000_0000;
      hi = 32'sh7fff_ffff;
    end else if (ph == 1) begin
      lo = signed'($urandom);
      if (lo == 32'sh7fff_ffff) lo = 32'sd0;
      hi = lo + 32'sd1;
    end else if ($urandom_range(0, 1)) begin
      lo = -32'($urandom_range(0, 100000));
      hi = 32'($urandom_range(1, 100000));
    end else begin
      lo = signed'($urandom);
      hi = signed'($urandom);
      if (lo > hi) begin
        t  = lo;
        lo = hi;
        hi = t;
      end
    end
    if (ph == 5) begin
      // straight order, so some writes may be refused
      write_reg(REG_LIMIT_LOW, lo);
      write_reg(REG_LIMIT_HIGH, hi);
    end else begin
      write_reg(REG_LIMIT_HIGH, 32'h7fff_ffff);
      write_reg(REG_LIMIT_LOW, lo);
      write_reg(REG_LIMIT_HIGH, hi);
    end
    n_settings++;
  endtask

  // result side: random stall per transfer, or a long hold on request
  initial begin
    out_ready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin : rx_loop
      int stall;
      stall = full_rate ? 0 : $urandom_range(0, 3);
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    pid_result_t want;
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      n_checked++;
      if (pending_drives.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding, drive %0d computed %0b",
                   $time, out_drive, out_computed);
      end else begin
        want = pending_drives.pop_front();
        if (want.computed) n_computed++;
        else n_manual++;
        if (out_drive !== want.drive) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: drive mismatch, expected %0d, actual %0d",
                     $time, want.drive, out_drive);
        end
        if (out_computed !== want.computed) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: computed mismatch, expected %0b, actual %0b",
                     $time, want.computed, out_computed);
        end
      end
    end
  end

  task automatic test_reset_defaults();
    // gains all zero, limits 0..255, zero error counts as one
    send_sample(16'sd0);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    wait_drained();
  endtask

  task automatic test_extreme_values();
    write_reg(REG_LIMIT_HIGH, 32'h7fff_ffff);
    write_reg(REG_LIMIT_LOW, 32'h8000_0000);
    write_reg(REG_SETPOINT, 32'h0000_7fff);
    write_reg(REG_GAIN_P, 32'h0000_7fff);
    write_reg(REG_GAIN_I, 32'h0000_7fff);
    write_reg(REG_GAIN_D, 32'hffff_8000);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    wait_drained();
    write_reg(REG_SETPOINT, 32'hffff_8000);
    write_reg(REG_GAIN_P, 32'hffff_8000);
    write_reg(REG_GAIN_I, 32'hffff_8000);
    write_reg(REG_GAIN_D, 32'h0000_7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sd0);
    wait_drained();
  endtask

  task automatic test_limit_writes();
    write_reg(REG_SETPOINT, 32'd0);
    write_reg(REG_GAIN_P, 32'd0);
    write_reg(REG_GAIN_D, 32'd0);
    write_reg(REG_GAIN_I, 32'd1000);
    write_reg(REG_LIMIT_HIGH, 32'h7fff_ffff);
    write_reg(REG_LIMIT_LOW, 32'h8000_0000);
    send_sample(-16'sd100);
    send_sample(-16'sd100);
    wait_drained();
    // shrinking the high limit pulls the integral down with it
    write_reg(REG_LIMIT_HIGH, 32'd5000);
    write_reg(REG_LIMIT_LOW, 32'd5000);
    write_reg(REG_LIMIT_HIGH, 32'h8000_0000);
    write_reg(REG_SPARE, 32'hffff_ffff);
    send_sample(16'sd0);
    wait_drained();
    write_reg(REG_LIMIT_LOW, -32'sd5000);
    write_reg(REG_GAIN_I, -32'sd1000);
    send_sample(16'sd100);
    wait_drained();
    write_reg(REG_LIMIT_LOW, 32'd4000);
    write_reg(REG_GAIN_I, 32'd0);
    send_sample(16'sd1);
    wait_drained();
  endtask

  task automatic test_manual_mode();
    write_reg(REG_AUTO_CFG, 32'd0);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    wait_drained();
    // limit writes in manual mode leave the integral alone
    write_reg(REG_LIMIT_LOW, -32'sd100);
    write_reg(REG_LIMIT_HIGH, 32'd100);
    write_reg(REG_GAIN_D, 32'd1);
    write_reg(REG_AUTO_CFG, 32'd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);
    wait_drained();
  endtask

  task automatic test_output_stall();
    full_rate    = 1'b1;
    hold_request = 1'b1;
    repeat (16) send_sample(pick_sample());
    full_rate = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_phases();
    int pause_at;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_random_config(ph);
      full_rate = (ph % 4 == 3);
      pause_at  = $urandom_range(10, ITEMS_PER_PHASE - 10);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // sender holds off until the pipe is empty once per phase
        if (i == pause_at) wait_drained();
        send_sample(pick_sample());
      end
      full_rate = 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_sample    = '0;
    full_rate    = 1'b0;
    hold_request = 1'b0;
    n_sent       = 0;
    n_checked    = 0;
    n_errors     = 0;
    n_computed   = 0;
    n_manual     = 0;
    n_settings   = 0;
    reset_pid_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extreme_values();
    test_limit_writes();
    test_manual_mode();
    test_output_stall();
    test_random_phases();
    wait_drained();

    if (pending_drives.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived", $time, pending_drives.size());
    end
    $display("run covered %0d samples over %0d random register settings plus directed cases",
             n_sent, n_settings);
    $display("results: %0d computed, %0d manual, %0d mismatches",
             n_computed, n_manual, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ips_pkg.sv
src/ips_cfg.sv
src/ips_core.sv
src/integer_pid_step_unit.sv
src/ips_checker.sv
test/integer_pid_step_unit_tb.sv
